// ===== rtl/dmpk_pkg.sv =====
package dmpk_pkg;

    localparam int SIZE_W       = 11;
    localparam int KEY_W        = 31;
    localparam int VAL_W        = 32;
    localparam int SUM_W        = 32;
    localparam int PAIR_W       = 64;
    localparam int CAPACITY_DEF = 1024;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key_m;
        logic [KEY_W-1:0] key_n;
        logic [VAL_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== rtl/dmpk_ram.sv =====
module dmpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/direct_mapped_pair_key_table_unit.sv =====
// Direct-mapped memo table keyed by the pair (key_m, key_n). The slot is the Cantor
// pairing value ((m+n+1)(m+n)/2 + n) modulo the effective table size (table_size,
// with 0 taken as 1 and values above CAPACITY taken as CAPACITY). After reset the
// block sweeps the slot memory once to clear all entries, with in_ready low;
// configuration writes are taken during the sweep. Each request then passes from
// acceptance to result through one multiply, one add, a radix-2 restoring modulo
// that shares a single compare/subtract, then one memory read and a read/update
// step. One request is in flight at a time; a new request is accepted while the
// previous result still waits on the output register.
module direct_mapped_pair_key_table_unit #(
    parameter int CAPACITY = dmpk_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [dmpk_pkg::SIZE_W-1:0]   cfg_wr_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [dmpk_pkg::KEY_W-1:0]    key_m,
    input  logic [dmpk_pkg::KEY_W-1:0]    key_n,
    input  logic [dmpk_pkg::VAL_W-1:0]    new_value,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic                          evicted,
    output logic [dmpk_pkg::KEY_W-1:0]    old_key_m,
    output logic [dmpk_pkg::KEY_W-1:0]    old_key_n,
    output logic [dmpk_pkg::VAL_W-1:0]    found_value
);

    import dmpk_pkg::*;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(PAIR_W);
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int CAP_CLIP = (CAPACITY > SIZE_MAX) ? SIZE_MAX : CAPACITY;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_LOOK  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] table_size_reg;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  m_reg, m_next;
    logic [KEY_W-1:0]  n_reg, n_next;
    logic [VAL_W-1:0]  v_reg, v_next;

    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;
    logic              evicted_reg, evicted_next;
    logic [KEY_W-1:0]  old_m_reg, old_m_next;
    logic [KEY_W-1:0]  old_n_reg, old_n_next;
    logic [VAL_W-1:0]  found_reg, found_next;

    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W:0]   trial;
    logic              out_free;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    slot_t             ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             slot;

    assign slot     = slot_t'(ram_rdata);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign trial    = {rem_reg, pair_reg[PAIR_W-1]};

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > CAP_CLIP)
        begin
            size_eff = SIZE_W'(CAP_CLIP);
        end
        else
        begin
            size_eff = table_size_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        size_next      = size_reg;
        rem_next       = rem_reg;
        pair_next      = pair_reg;
        sum_next       = sum_reg;
        op_next        = op_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        evicted_next   = evicted_reg;
        old_m_next     = old_m_reg;
        old_n_next     = old_n_reg;
        found_next     = found_reg;
        ram_we         = 1'b0;
        ram_addr       = IDX_W'(rem_reg);
        ram_wdata      = '{valid: 1'b1, key_m: m_reg, key_n: n_reg, value: v_reg};

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    m_next     = key_m;
                    n_next     = key_n;
                    v_next     = new_value;
                    sum_next   = SUM_W'(key_m) + SUM_W'(key_n);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                pair_next  = PAIR_W'(sum_reg + 1'b1) * PAIR_W'(sum_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                pair_next  = (pair_reg >> 1) + PAIR_W'(n_reg);
                size_next  = size_eff;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (trial >= {1'b0, size_reg})
                begin
                    rem_next = SIZE_W'(trial - {1'b0, size_reg});
                end
                else
                begin
                    rem_next = trial[SIZE_W-1:0];
                end
                pair_next = pair_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PAIR_W - 1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    evicted_next   = 1'b0;
                    old_m_next     = '0;
                    old_n_next     = '0;
                    found_next     = '0;
                    if (op_reg == OP_INSERT)
                    begin
                        ram_we = 1'b1;
                        if (slot.valid)
                        begin
                            evicted_next = 1'b1;
                            old_m_next   = slot.key_m;
                            old_n_next   = slot.key_n;
                            found_next   = slot.value;
                        end
                    end
                    else if (slot.valid && slot.key_m == m_reg && slot.key_n == n_reg)
                    begin
                        hit_next   = 1'b1;
                        found_next = slot.value;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            cnt_reg        <= '0;
            table_size_reg <= SIZE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        rem_reg     <= rem_next;
        pair_reg    <= pair_next;
        sum_reg     <= sum_next;
        op_reg      <= op_next;
        m_reg       <= m_next;
        n_reg       <= n_next;
        v_reg       <= v_next;
        hit_reg     <= hit_next;
        evicted_reg <= evicted_next;
        old_m_reg   <= old_m_next;
        old_n_reg   <= old_n_next;
        found_reg   <= found_next;
    end

    dmpk_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign evicted     = evicted_reg;
    assign old_key_m   = old_m_reg;
    assign old_key_n   = old_n_reg;
    assign found_value = found_reg;

endmodule

// ===== tb/tb_direct_mapped_pair_key_table_unit.sv =====
module tb_direct_mapped_pair_key_table_unit;

    import dmpk_pkg::*;

    localparam int          SLOTS        = CAPACITY_DEF;
    localparam int          LIMIT        = 1000000;
    localparam int          SETTLE       = 80;
    localparam int          MAX_REPORTS  = 10;
    localparam int          POOL_DEPTH   = 32;
    localparam int          PHASE_ITEMS  = 86;
    localparam [KEY_W-1:0]  KEY_MAX      = {KEY_W{1'b1}};

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] old_m;
        logic [KEY_W-1:0] old_n;
        logic [VAL_W-1:0] found;
    } table_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [SIZE_W-1:0]   cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic                opcode;
    logic [KEY_W-1:0]    key_m;
    logic [KEY_W-1:0]    key_n;
    logic [VAL_W-1:0]    new_value;
    logic                out_valid;
    logic                out_ready;
    logic                hit;
    logic                evicted;
    logic [KEY_W-1:0]    old_key_m;
    logic [KEY_W-1:0]    old_key_n;
    logic [VAL_W-1:0]    found_value;

    // shadow copy of the table
    logic                shadow_valid [SLOTS];
    logic [KEY_W-1:0]    shadow_m     [SLOTS];
    logic [KEY_W-1:0]    shadow_n     [SLOTS];
    logic [VAL_W-1:0]    shadow_value [SLOTS];
    logic [SIZE_W-1:0]   size_reg;

    table_result_t       pending_results [$];
    logic [2*KEY_W-1:0]  key_pool [$];
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  cycle_count = 0;
    bit                  no_idle = 1'b0;

    direct_mapped_pair_key_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key_m       (key_m),
        .key_n       (key_n),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .evicted     (evicted),
        .old_key_m   (old_key_m),
        .old_key_n   (old_key_n),
        .found_value (found_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("direct_mapped_pair_key_table_unit test failed");
            $finish;
        end
    end

    function automatic int unsigned pairing_slot(logic [KEY_W-1:0] m, logic [KEY_W-1:0] n);
        logic [PAIR_W-1:0] sum;
        logic [PAIR_W-1:0] pairing;
        int unsigned       span;
        sum = PAIR_W'(m) + PAIR_W'(n);
        pairing = ((sum + 64'd1) * sum) / 64'd2 + PAIR_W'(n);
        span = (size_reg == '0) ? 1 : ((size_reg > SLOTS) ? SLOTS : int'(size_reg));
        return int'(pairing % PAIR_W'(span));
    endfunction

    function automatic table_result_t table_access(logic op, logic [KEY_W-1:0] m,
                                                   logic [KEY_W-1:0] n, logic [VAL_W-1:0] v);
        table_result_t r;
        int unsigned   idx;
        r = '0;
        idx = pairing_slot(m, n);
        if (op == OP_LOOKUP)
        begin
            if (shadow_valid[idx] && shadow_m[idx] == m && shadow_n[idx] == n)
            begin
                r.hit = 1'b1;
                r.found = shadow_value[idx];
            end
        end
        else
        begin
            if (shadow_valid[idx])
            begin
                r.evicted = 1'b1;
                r.old_m = shadow_m[idx];
                r.old_n = shadow_n[idx];
                r.found = shadow_value[idx];
            end
            shadow_valid[idx] = 1'b1;
            shadow_m[idx] = m;
            shadow_n[idx] = n;
            shadow_value[idx] = v;
        end
        return r;
    endfunction

    // valid stays high after acceptance; lowered here only when a gap follows
    task automatic send_request(logic op, logic [KEY_W-1:0] m, logic [KEY_W-1:0] n,
                                logic [VAL_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        key_m <= m;
        key_n <= n;
        new_value <= v;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(table_access(op, m, n, v));
        if (op == OP_INSERT)
        begin
            key_pool.push_back({m, n});
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] size);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size;
        size_reg = size;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_result();
        table_result_t exp_r;
        table_result_t got;
        got = '{hit, evicted, old_key_m, old_key_n, found_value};
        results_seen++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: no request outstanding, got hit=%0d ev=%0d m=%h n=%h v=%h",
                         results_seen, got.hit, got.evicted, got.old_m, got.old_n, got.found);
        end
        else
        begin
            exp_r = pending_results.pop_front();
            if (got.hit !== exp_r.hit || got.evicted !== exp_r.evicted ||
                got.old_m !== exp_r.old_m || got.old_n !== exp_r.old_n ||
                got.found !== exp_r.found)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d: exp hit=%0d ev=%0d m=%h n=%h v=%h", results_seen,
                             exp_r.hit, exp_r.evicted, exp_r.old_m, exp_r.old_n, exp_r.found);
                    $display("result %0d: got hit=%0d ev=%0d m=%h n=%h v=%h", results_seen,
                             got.hit, got.evicted, got.old_m, got.old_n, got.found);
                end
            end
        end
    endtask

    initial
    begin : receiver
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            out_ready <= (stall == 0);
            do @(posedge clk); while (!out_valid);
            if (stall > 0)
            begin
                repeat (stall - 1) @(posedge clk);
                out_ready <= 1'b1;
                @(posedge clk);
            end
            check_result();
        end
    end

    task automatic pick_key(output logic [KEY_W-1:0] m, output logic [KEY_W-1:0] n);
        int          sel;
        int unsigned k;
        sel = $urandom_range(0, 99);
        if (sel < 40 && key_pool.size() > 0)
        begin
            k = $urandom_range(0, key_pool.size() - 1);
            m = key_pool[k][2*KEY_W-1:KEY_W];
            n = key_pool[k][KEY_W-1:0];
        end
        else if (sel < 65)
        begin
            m = KEY_W'($urandom_range(0, 15));
            n = KEY_W'($urandom_range(0, 15));
        end
        else if (sel < 85)
        begin
            m = KEY_W'($urandom);
            n = KEY_W'($urandom);
        end
        else
        begin
            m = KEY_MAX - KEY_W'($urandom_range(0, 15));
            n = KEY_MAX - KEY_W'($urandom_range(0, 15));
        end
    endtask

    task automatic test_empty_table();
        send_request(OP_LOOKUP, '0, '0, 32'h1234_5678);
        send_request(OP_INSERT, '0, '0, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, '0, '0, '0);
        send_request(OP_LOOKUP, '0, 31'd1, '0);
        send_request(OP_INSERT, KEY_MAX, KEY_MAX, '0);
        send_request(OP_LOOKUP, KEY_MAX, KEY_MAX, 32'hFFFF_FFFF);
        send_request(OP_INSERT, KEY_MAX, KEY_MAX, 32'hA5A5_A5A5);
        wait_drain();
    endtask

    // size zero folds everything onto slot 0; oversize clamps to capacity
    task automatic test_size_limits();
        write_size('0);
        send_request(OP_INSERT, 31'd5, 31'd9, 32'h0000_0001);
        send_request(OP_INSERT, 31'd3, 31'd3, 32'h8000_0000);
        send_request(OP_LOOKUP, 31'd5, 31'd9, '0);
        send_request(OP_LOOKUP, 31'd3, 31'd3, '0);
        write_size({SIZE_W{1'b1}});
        send_request(OP_LOOKUP, KEY_MAX, KEY_MAX, '0);
        send_request(OP_INSERT, 31'h5555_5555, 31'h2AAA_AAAA, 32'h5A5A_5A5A);
        wait_drain();
    endtask

    // entries stay put across a resize and come back when the size grows
    task automatic test_resize_filled();
        write_size(SIZE_RESET);
        send_request(OP_INSERT, 31'd10, 31'd20, 32'h0000_1020);
        send_request(OP_INSERT, 31'd100, 31'd7, 32'h0001_0007);
        send_request(OP_INSERT, 31'd1, 31'd1, 32'h0000_0101);
        send_request(OP_INSERT, 31'd0, 31'd5, 32'h0000_0005);
        write_size(11'd4);
        send_request(OP_LOOKUP, 31'd10, 31'd20, '0);
        send_request(OP_LOOKUP, 31'd1, 31'd1, '0);
        send_request(OP_INSERT, 31'd2, 31'd2, 32'h0000_0202);
        write_size(SIZE_RESET);
        send_request(OP_LOOKUP, 31'd10, 31'd20, '0);
        send_request(OP_LOOKUP, 31'd100, 31'd7, '0);
        send_request(OP_LOOKUP, 31'd2, 31'd2, '0);
        write_size(11'd1025);
        send_request(OP_INSERT, 31'd1, 31'd0, 32'h0000_0100);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        logic [SIZE_W-1:0] sizes [12];
        logic [KEY_W-1:0]  m;
        logic [KEY_W-1:0]  n;
        sizes = '{11'd1, 11'd2, 11'd3, 11'd7, 11'd16, 11'd61, 11'd0,
                  SIZE_RESET, 11'd2047, 11'd1025, 11'd300, 11'd5};
        sizes[10] = SIZE_W'($urandom_range(0, 2047));
        for (int p = 0; p < 12; p++)
        begin
            write_size(sizes[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                pick_key(m, n);
                send_request(logic'($urandom_range(0, 1)), m, n, $urandom);
            end
        end
        no_idle = 1'b0;
        wait_drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        opcode <= OP_LOOKUP;
        key_m <= '0;
        key_n <= '0;
        new_value <= '0;
        size_reg = SIZE_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_m[i] = '0;
            shadow_n[i] = '0;
            shadow_value[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_size_limits();
        test_resize_filled();
        test_random_traffic();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("direct_mapped_pair_key_table_unit test passed");
        else
            $display("direct_mapped_pair_key_table_unit test failed");
        $finish;
    end

endmodule
